>>> rtl/pcl_pkg.sv
// pcl_pkg: shared types and constants for the positional circular list.
// Field widths, request and status codes, sequencer state type.
// No dependencies.
package pcl_pkg;

    localparam int REQ_W = 2;
    localparam int POS_W = 5;
    localparam int VAL_W = 32;
    localparam int STS_W = 2;
    localparam int CNT_W = 5;

    // padded stream widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DUMP   = 2'd2;

    localparam logic [STS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STS_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STS_W-1:0] STAT_FULL  = 2'd2;
    localparam logic [STS_W-1:0] STAT_EMPTY = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ALLOC_WAIT,
        S_INS_LINK,
        S_WALK,
        S_NEXT_WAIT,
        S_INS_SPLICE,
        S_INS_PRED,
        S_DEL_HEAD_WAIT,
        S_DEL_NEXT_WAIT,
        S_DEL_FREE,
        S_DUMP,
        S_FINISH
    } pcl_state_t;

endpackage

>>> rtl/pcl_ram.sv
// pcl_ram: simple dual-port synchronous RAM, one write and one read port.
// Read data registered, held while no read is issued.
// No dependencies.
module pcl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                          aclk,
    input  logic                          we,
    input  logic [$clog2(DEPTH)-1:0]      waddr,
    input  logic [WIDTH-1:0]              wdata,
    input  logic                          re,
    input  logic [$clog2(DEPTH)-1:0]      raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/positional_circular_list.sv
// positional_circular_list: top level, sequencer plus value and link stores; uses pcl_pkg, pcl_ram.
// Insert at position p >= 1 walks the ring to its predecessor; at position 0 (or on an empty
// list) it does not walk, and reusing a freed slot adds a read step; delete walks for p >= 2.
// Dump: one transaction per cycle while m_tready holds; errors go straight to the result.
// One request at a time: s_tready returns the cycle after the final result is loaded.
// Reset empties the list and idles the sequencer and output; RAM contents are not cleared.
module positional_circular_list
    import pcl_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [4:0] position, [36:5] item_value
    input  logic [REQ_W-1:0]     s_tuser,   // [1:0] req_type
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] result_value, [36:32] list_count
    output logic [STS_W-1:0]     m_tuser,   // [1:0] status
    output logic                 m_tlast    // last_result
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    // sequencer and list state
    pcl_state_t state_reg, state_next;

    logic [REQ_W-1:0]        req_reg, req_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic signed [VAL_W-1:0] item_reg, item_next;

    logic [CW-1:0] count_reg, count_next;      // elements on the list
    logic [CW-1:0] fresh_reg, fresh_next;      // slots ever allocated
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [AW-1:0] free_head_reg, free_head_next; // top of freed-slot chain

    // walk and splice working registers
    logic [AW-1:0] cur_reg, cur_next;
    logic [CW-1:0] steps_reg, steps_next;
    logic          pending_reg, pending_next;
    logic [AW-1:0] slot_reg, slot_next;
    logic [AW-1:0] nxt_reg, nxt_next;
    logic [AW-1:0] victim_reg, victim_next;
    logic [CW-1:0] idx_reg, idx_next;

    logic [STS_W-1:0]        res_status_reg, res_status_next;
    logic signed [VAL_W-1:0] res_value_reg, res_value_next;

    // output register
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [STS_W-1:0]        m_status_reg, m_status_next;
    logic signed [VAL_W-1:0] m_value_reg, m_value_next;
    logic [CNT_W-1:0]        m_count_reg, m_count_next;
    logic                    m_last_reg, m_last_next;
    logic                    out_load;

    // memory ports
    logic             value_we, value_re;
    logic [AW-1:0]    value_waddr, value_raddr;
    logic [VAL_W-1:0] value_wdata, value_rdata;
    logic             link_we, link_re;
    logic [AW-1:0]    link_waddr, link_raddr;
    logic [AW-1:0]    link_wdata, link_rdata;

    // decode helpers
    logic [CMPW-1:0] pos_ext, cnt_ext;
    logic            ins_range, del_range, is_full, list_empty, chain_nonempty;
    logic            out_free, walk_done, dump_last;
    logic [AW-1:0]   walk_addr;

    assign pos_ext        = CMPW'(pos_reg);
    assign cnt_ext        = CMPW'(count_reg);
    assign ins_range      = pos_ext > cnt_ext;
    assign del_range      = (pos_reg == '0) || (pos_ext > cnt_ext);
    assign is_full        = count_reg == CW'(CAPACITY);
    assign list_empty     = count_reg == '0;
    // freed slots exist whenever more slots were handed out than are in use
    assign chain_nonempty = fresh_reg != count_reg;
    assign out_free       = !m_tvalid_reg || m_tready;
    // first step of a walk starts from cur, later steps chase the read data
    assign walk_addr      = pending_reg ? link_rdata : cur_reg;
    assign walk_done      = steps_reg == '0;
    assign dump_last      = idx_reg == (count_reg - CW'(1));

    pcl_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_value_ram (
        .aclk  (aclk),
        .we    (value_we),
        .waddr (value_waddr),
        .wdata (value_wdata),
        .re    (value_re),
        .raddr (value_raddr),
        .rdata (value_rdata)
    );

    pcl_ram #(
        .WIDTH (AW),
        .DEPTH (CAPACITY)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (req_reg)
                    REQ_INSERT: begin
                        if (ins_range || is_full) begin
                            state_next = S_FINISH;
                        end else if (chain_nonempty) begin
                            state_next = S_ALLOC_WAIT;
                        end else begin
                            state_next = S_INS_LINK;
                        end
                    end
                    REQ_DELETE: begin
                        if (list_empty || del_range) begin
                            state_next = S_FINISH;
                        end else if (pos_reg == POS_W'(1)) begin
                            state_next = S_DEL_HEAD_WAIT;
                        end else begin
                            state_next = S_WALK;
                        end
                    end
                    REQ_DUMP: begin
                        state_next = list_empty ? S_FINISH : S_DUMP;
                    end
                    default: begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_ALLOC_WAIT:    state_next = S_INS_LINK;
            S_INS_LINK: begin
                if (list_empty) begin
                    state_next = S_FINISH;
                end else if (pos_reg == '0) begin
                    state_next = S_INS_PRED;
                end else begin
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                if (walk_done) begin
                    state_next = S_NEXT_WAIT;
                end
            end
            S_NEXT_WAIT: begin
                state_next = (req_reg == REQ_INSERT) ? S_INS_SPLICE : S_DEL_NEXT_WAIT;
            end
            S_INS_SPLICE:    state_next = S_INS_PRED;
            S_INS_PRED:      state_next = S_FINISH;
            S_DEL_HEAD_WAIT: state_next = S_DEL_FREE;
            S_DEL_NEXT_WAIT: state_next = S_DEL_FREE;
            S_DEL_FREE:      state_next = S_FINISH;
            S_DUMP: begin
                if (out_free && dump_last) begin
                    state_next = S_IDLE;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath, memory controls and output register loading
    always_comb begin
        req_next        = req_reg;
        pos_next        = pos_reg;
        item_next       = item_reg;
        count_next      = count_reg;
        fresh_next      = fresh_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        free_head_next  = free_head_reg;
        cur_next        = cur_reg;
        steps_next      = steps_reg;
        pending_next    = pending_reg;
        slot_next       = slot_reg;
        nxt_next        = nxt_reg;
        victim_next     = victim_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        m_status_next   = m_status_reg;
        m_value_next    = m_value_reg;
        m_count_next    = m_count_reg;
        m_last_next     = m_last_reg;
        out_load        = 1'b0;

        value_we    = 1'b0;
        value_waddr = slot_reg;
        value_wdata = item_reg;
        value_re    = 1'b0;
        value_raddr = head_reg;
        link_we     = 1'b0;
        link_waddr  = slot_reg;
        link_wdata  = slot_reg;
        link_re     = 1'b0;
        link_raddr  = head_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    req_next  = s_tuser;
                    pos_next  = s_tdata[POS_W-1:0];
                    item_next = s_tdata[POS_W+VAL_W-1:POS_W];
                end
            end
            S_DECODE: begin
                res_status_next = STAT_OK;
                res_value_next  = '0;
                case (req_reg)
                    REQ_INSERT: begin
                        if (ins_range) begin
                            res_status_next = STAT_RANGE;
                        end else if (is_full) begin
                            res_status_next = STAT_FULL;
                        end else if (chain_nonempty) begin
                            // pop the freed-slot chain
                            link_re    = 1'b1;
                            link_raddr = free_head_reg;
                            slot_next  = free_head_reg;
                        end else begin
                            slot_next  = fresh_reg[AW-1:0];
                            fresh_next = fresh_reg + CW'(1);
                        end
                    end
                    REQ_DELETE: begin
                        if (list_empty) begin
                            res_status_next = STAT_EMPTY;
                        end else if (del_range) begin
                            res_status_next = STAT_RANGE;
                        end else if (pos_reg == POS_W'(1)) begin
                            victim_next = head_reg;
                            link_re     = 1'b1;
                            link_raddr  = head_reg;
                            value_re    = 1'b1;
                            value_raddr = head_reg;
                        end else begin
                            cur_next     = head_reg;
                            steps_next   = CW'(pos_ext - CMPW'(2));
                            pending_next = 1'b0;
                        end
                    end
                    REQ_DUMP: begin
                        if (list_empty) begin
                            res_status_next = STAT_EMPTY;
                        end else begin
                            link_re     = 1'b1;
                            link_raddr  = head_reg;
                            value_re    = 1'b1;
                            value_raddr = head_reg;
                            idx_next    = '0;
                        end
                    end
                    default: begin
                        res_status_next = STAT_RANGE;
                    end
                endcase
            end
            S_ALLOC_WAIT: begin
                free_head_next = link_rdata;
            end
            S_INS_LINK: begin
                value_we    = 1'b1;
                value_waddr = slot_reg;
                value_wdata = item_reg;
                if (list_empty) begin
                    // single element ring points at itself
                    link_we    = 1'b1;
                    link_waddr = slot_reg;
                    link_wdata = slot_reg;
                    head_next  = slot_reg;
                    tail_next  = slot_reg;
                    count_next = count_reg + CW'(1);
                end else if (pos_reg == '0) begin
                    // new head; tail re-linked in the predecessor step
                    link_we    = 1'b1;
                    link_waddr = slot_reg;
                    link_wdata = head_reg;
                    head_next  = slot_reg;
                    cur_next   = tail_reg;
                end else begin
                    cur_next     = head_reg;
                    steps_next   = CW'(pos_ext - CMPW'(1));
                    pending_next = 1'b0;
                end
            end
            S_WALK: begin
                // one link per cycle; the final read fetches next of predecessor
                link_re      = 1'b1;
                link_raddr   = walk_addr;
                cur_next     = walk_addr;
                pending_next = !walk_done;
                if (!walk_done) begin
                    steps_next = steps_reg - CW'(1);
                end
            end
            S_NEXT_WAIT: begin
                if (req_reg == REQ_INSERT) begin
                    nxt_next = link_rdata;
                end else begin
                    victim_next = link_rdata;
                    link_re     = 1'b1;
                    link_raddr  = link_rdata;
                    value_re    = 1'b1;
                    value_raddr = link_rdata;
                end
            end
            S_INS_SPLICE: begin
                link_we    = 1'b1;
                link_waddr = slot_reg;
                link_wdata = nxt_reg;
            end
            S_INS_PRED: begin
                link_we    = 1'b1;
                link_waddr = cur_reg;
                link_wdata = slot_reg;
                if (pos_ext == cnt_ext) begin
                    tail_next = slot_reg;
                end
                count_next = count_reg + CW'(1);
            end
            S_DEL_HEAD_WAIT: begin
                res_value_next = value_rdata;
                if (count_reg == CW'(1)) begin
                    head_next = '0;
                    tail_next = '0;
                end else begin
                    head_next  = link_rdata;
                    link_we    = 1'b1;
                    link_waddr = tail_reg;
                    link_wdata = link_rdata;
                end
            end
            S_DEL_NEXT_WAIT: begin
                res_value_next = value_rdata;
                link_we        = 1'b1;
                link_waddr     = cur_reg;
                link_wdata     = link_rdata;
                if (victim_reg == tail_reg) begin
                    tail_next = cur_reg;
                end
            end
            S_DEL_FREE: begin
                // push victim onto freed-slot chain
                link_we        = 1'b1;
                link_waddr     = victim_reg;
                link_wdata     = free_head_reg;
                free_head_next = victim_reg;
                count_next     = count_reg - CW'(1);
            end
            S_DUMP: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    m_status_next = STAT_OK;
                    m_value_next  = value_rdata;
                    m_count_next  = CNT_W'(count_reg);
                    m_last_next   = dump_last;
                    if (!dump_last) begin
                        link_re     = 1'b1;
                        link_raddr  = link_rdata;
                        value_re    = 1'b1;
                        value_raddr = link_rdata;
                        idx_next    = idx_reg + CW'(1);
                    end
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    m_status_next = res_status_reg;
                    m_value_next  = res_value_reg;
                    m_count_next  = CNT_W'(count_reg);
                    m_last_next   = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            fresh_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            free_head_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            fresh_reg     <= fresh_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            free_head_reg <= free_head_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // payload and working registers
    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        pos_reg        <= pos_next;
        item_reg       <= item_next;
        cur_reg        <= cur_next;
        steps_reg      <= steps_next;
        pending_reg    <= pending_next;
        slot_reg       <= slot_next;
        nxt_reg        <= nxt_next;
        victim_reg     <= victim_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        m_status_reg   <= m_status_next;
        m_value_reg    <= m_value_next;
        m_count_reg    <= m_count_next;
        m_last_reg     <= m_last_next;
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - VAL_W - CNT_W){1'b0}}, m_count_reg, m_value_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    // list never holds more elements than slots handed out, nor more than fit
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg <= fresh_reg) && (fresh_reg <= CW'(CAPACITY)))
        else $error("element count exceeds allocated slots");

    // an accepted transaction keeps the request side closed next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while previous one in progress");

    // error statuses are always single, final results
    a_error_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != STAT_OK)) |-> m_tlast)
        else $error("error result not flagged last");

    // a dump only runs over a non-empty list
    a_dump_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DUMP) |-> (count_reg != '0))
        else $error("dump running on empty list");

endmodule
